### hw/rtl/stt_pkg.sv
package stt_pkg;

  // Most result items that one source byte can cause
  localparam int MAX_RES = 8;

  // Bytes above this value are invalid outside strings and comments
  localparam logic [7:0] CHAR_MAX = 8'd127;

  // Keywords, matched after uppercasing
  localparam logic [23:0] KW_YAZ   = "YAZ";
  localparam logic [31:0] KW_EGER  = "EGER";
  localparam logic [23:0] KW_OKU   = "OKU";
  localparam logic [39:0] KW_DONGU = "DONGU";
  localparam logic [31:0] KW_FONK  = "FONK";
  localparam logic [15:0] KW_VE    = "VE";
  localparam logic [31:0] KW_VEYA  = "VEYA";

  typedef enum logic [1:0] {
    KIND_VALUE = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } res_kind_t;

  typedef enum logic [2:0] {
    CLS_KEYWORD = 3'd0,
    CLS_IDENT   = 3'd1,
    CLS_NUMBER  = 3'd2,
    CLS_STRING  = 3'd3,
    CLS_SIGN    = 3'd4,
    CLS_OP      = 3'd5,
    CLS_COMPARE = 3'd6
  } tok_class_t;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_WORD    = 4'd1,
    MODE_NUM     = 4'd2,
    MODE_STR     = 4'd3,
    MODE_COMMENT = 4'd4,
    MODE_SLASH   = 4'd5,
    MODE_BANG    = 4'd6,
    MODE_EQ      = 4'd7,
    MODE_ANGLE   = 4'd8,
    MODE_HALT    = 4'd9
  } scan_mode_t;

  // One result item without its line number
  typedef struct packed {
    res_kind_t  kind;
    tok_class_t cls;
    logic [7:0] ch;
  } res_ent_t;

  // All results caused by one source byte
  typedef struct packed {
    res_ent_t [MAX_RES-1:0] ent;
    logic [3:0]             cnt;
    logic [15:0]            line;
  } job_t;

endpackage

### hw/rtl/stt_front.sv
module stt_front #(
  parameter int LINE_COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        source_byte,
  input  logic              end_of_source,
  input  logic              src_valid,
  output logic              src_ready,
  input  logic              q_ready,
  output logic              push,
  output stt_pkg::job_t     job
);

  localparam int LW = (LINE_COUNT_BITS > 16) ? LINE_COUNT_BITS : 16;

  typedef struct packed {
    stt_pkg::res_ent_t [stt_pkg::MAX_RES-1:0] ent;
    logic [3:0]                               cnt;
  } seg_t;

  localparam logic [7:0] CH_LF = 8'h0A;

  // Scanner state
  stt_pkg::scan_mode_t        mode;
  logic [4:0][7:0]            word_hold;
  logic [2:0]                 word_length;
  logic                       word_overflowed;
  logic                       dot_seen;
  logic                       pending_angle;
  logic [LINE_COUNT_BITS-1:0] line_count;

  stt_pkg::scan_mode_t        mode_mid;
  logic [2:0]                 len_mid;
  logic                       ovf_mid;
  logic                       dot_mid;
  logic                       ang_mid;
  logic [LINE_COUNT_BITS-1:0] line_mid;
  logic [LINE_COUNT_BITS-1:0] line_inc;
  logic [LINE_COUNT_BITS-1:0] line_emit;
  logic [LW-1:0]              line_wide;
  logic                       hold_we;
  logic [2:0]                 hold_idx;
  logic [4:0][7:0]            hold_eff;
  logic                       do_fresh;
  logic                       accept;
  seg_t                       seg_a;
  seg_t                       seg_b;
  seg_t                       seg_c;

  stt_pkg::scan_mode_t        mode_next;
  logic [2:0]                 word_length_next;
  logic                       word_overflowed_next;
  logic                       dot_seen_next;
  logic                       pending_angle_next;
  logic [LINE_COUNT_BITS-1:0] line_count_next;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic stt_pkg::res_ent_t mk(input stt_pkg::res_kind_t k,
                                           input stt_pkg::tok_class_t c,
                                           input logic [7:0] ch);
    stt_pkg::res_ent_t e;
    e.kind = k;
    e.cls  = c;
    e.ch   = ch;
    return e;
  endfunction

  function automatic seg_t one(input stt_pkg::res_kind_t k,
                               input stt_pkg::tok_class_t c,
                               input logic [7:0] ch);
    seg_t s;
    s        = '0;
    s.ent[0] = mk(k, c, ch);
    s.cnt    = 4'd1;
    return s;
  endfunction

  // Single-character token: its character, then its end
  function automatic seg_t pair(input logic [7:0] ch, input stt_pkg::tok_class_t c);
    seg_t s;
    s        = '0;
    s.ent[0] = mk(stt_pkg::KIND_VALUE, c, ch);
    s.ent[1] = mk(stt_pkg::KIND_END, c, 8'h00);
    s.cnt    = 4'd2;
    return s;
  endfunction

  // Two-character compare token
  function automatic seg_t triple(input logic [7:0] c1, input logic [7:0] c2);
    seg_t s;
    s        = '0;
    s.ent[0] = mk(stt_pkg::KIND_VALUE, stt_pkg::CLS_COMPARE, c1);
    s.ent[1] = mk(stt_pkg::KIND_VALUE, stt_pkg::CLS_COMPARE, c2);
    s.ent[2] = mk(stt_pkg::KIND_END, stt_pkg::CLS_COMPARE, 8'h00);
    s.cnt    = 4'd3;
    return s;
  endfunction

  function automatic logic is_keyword(input logic [4:0][7:0] up, input logic [2:0] len);
    return (len == 3'd3 && {up[0], up[1], up[2]} == stt_pkg::KW_YAZ) ||
           (len == 3'd4 && {up[0], up[1], up[2], up[3]} == stt_pkg::KW_EGER) ||
           (len == 3'd3 && {up[0], up[1], up[2]} == stt_pkg::KW_OKU) ||
           (len == 3'd5 && {up[0], up[1], up[2], up[3], up[4]} == stt_pkg::KW_DONGU) ||
           (len == 3'd4 && {up[0], up[1], up[2], up[3]} == stt_pkg::KW_FONK) ||
           (len == 3'd2 && {up[0], up[1]} == stt_pkg::KW_VE) ||
           (len == 3'd4 && {up[0], up[1], up[2], up[3]} == stt_pkg::KW_VEYA);
  endfunction

  // Close a word: keyword check on the held characters, or just the end
  // item once the word has outgrown the hold
  function automatic seg_t end_word(input logic [4:0][7:0] hold, input logic [2:0] len,
                                    input logic ovf);
    seg_t                s;
    logic [4:0][7:0]     up;
    logic                kw;
    stt_pkg::tok_class_t c;
    s = '0;
    for (int i = 0; i < 5; i++) begin
      up[i] = to_upper(hold[i]);
    end
    kw = is_keyword(up, len);
    if (kw) begin
      c = stt_pkg::CLS_KEYWORD;
    end else begin
      c = stt_pkg::CLS_IDENT;
    end
    if (ovf) begin
      s.ent[0] = mk(stt_pkg::KIND_END, stt_pkg::CLS_IDENT, 8'h00);
      s.cnt    = 4'd1;
    end else begin
      for (int i = 0; i < 5; i++) begin
        if (3'(i) < len) begin
          s.ent[i] = mk(stt_pkg::KIND_VALUE, c, kw ? up[i] : hold[i]);
        end
      end
      s.ent[len] = mk(stt_pkg::KIND_END, c, 8'h00);
      s.cnt      = {1'b0, len} + 4'd1;
    end
    return s;
  endfunction

  assign src_ready = q_ready;
  assign accept    = src_valid && q_ready;
  assign line_inc  = (line_count != '1) ? line_count + LINE_COUNT_BITS'(1) : line_count;

  // Classify the byte against the current mode, then any fresh start, then the flush
  always_comb begin
    seg_a    = '0;
    seg_b    = '0;
    seg_c    = '0;
    do_fresh = 1'b0;
    mode_mid = mode;
    len_mid  = word_length;
    ovf_mid  = word_overflowed;
    dot_mid  = dot_seen;
    ang_mid  = pending_angle;
    line_mid = line_count;
    hold_we  = 1'b0;
    hold_idx = 3'd0;

    unique case (mode)
      stt_pkg::MODE_HALT: begin
      end
      stt_pkg::MODE_WORD: begin
        if (is_alpha(source_byte) || is_digit(source_byte) || source_byte == "_") begin
          if (word_overflowed) begin
            seg_a = one(stt_pkg::KIND_VALUE, stt_pkg::CLS_IDENT, source_byte);
          end else if (word_length < 3'd5) begin
            hold_we  = 1'b1;
            hold_idx = word_length;
            len_mid  = word_length + 3'd1;
          end else begin
            for (int i = 0; i < 5; i++) begin
              seg_a.ent[i] = mk(stt_pkg::KIND_VALUE, stt_pkg::CLS_IDENT, word_hold[i]);
            end
            seg_a.ent[5] = mk(stt_pkg::KIND_VALUE, stt_pkg::CLS_IDENT, source_byte);
            seg_a.cnt    = 4'd6;
            ovf_mid      = 1'b1;
          end
        end else begin
          seg_a    = end_word(word_hold, word_length, word_overflowed);
          do_fresh = 1'b1;
        end
      end
      stt_pkg::MODE_NUM: begin
        if (is_digit(source_byte)) begin
          seg_a = one(stt_pkg::KIND_VALUE, stt_pkg::CLS_NUMBER, source_byte);
        end else if (source_byte == "." && !dot_seen) begin
          dot_mid = 1'b1;
          seg_a   = one(stt_pkg::KIND_VALUE, stt_pkg::CLS_NUMBER, source_byte);
        end else begin
          seg_a    = one(stt_pkg::KIND_END, stt_pkg::CLS_NUMBER, 8'h00);
          do_fresh = 1'b1;
        end
      end
      stt_pkg::MODE_STR: begin
        if (source_byte == "\"") begin
          seg_a    = one(stt_pkg::KIND_END, stt_pkg::CLS_STRING, 8'h00);
          mode_mid = stt_pkg::MODE_IDLE;
        end else begin
          if (source_byte == CH_LF) begin
            line_mid = line_inc;
          end
          seg_a = one(stt_pkg::KIND_VALUE, stt_pkg::CLS_STRING, source_byte);
        end
      end
      stt_pkg::MODE_COMMENT: begin
        do_fresh = (source_byte == CH_LF);
      end
      stt_pkg::MODE_SLASH: begin
        if (source_byte == "/") begin
          mode_mid = stt_pkg::MODE_COMMENT;
        end else begin
          seg_a    = pair("/", stt_pkg::CLS_OP);
          do_fresh = 1'b1;
        end
      end
      stt_pkg::MODE_BANG: begin
        if (source_byte == "=") begin
          seg_a    = triple("!", "=");
          mode_mid = stt_pkg::MODE_IDLE;
        end else begin
          do_fresh = 1'b1;
        end
      end
      stt_pkg::MODE_EQ: begin
        if (source_byte == "=") begin
          seg_a    = triple("=", "=");
          mode_mid = stt_pkg::MODE_IDLE;
        end else begin
          seg_a    = pair("=", stt_pkg::CLS_SIGN);
          do_fresh = 1'b1;
        end
      end
      stt_pkg::MODE_ANGLE: begin
        if (source_byte == "=") begin
          seg_a    = triple(pending_angle ? ">" : "<", "=");
          mode_mid = stt_pkg::MODE_IDLE;
        end else begin
          seg_a    = pair(pending_angle ? ">" : "<", stt_pkg::CLS_COMPARE);
          do_fresh = 1'b1;
        end
      end
      default: begin
        do_fresh = 1'b1;
      end
    endcase

    // Start afresh from this byte
    if (do_fresh) begin
      mode_mid = stt_pkg::MODE_IDLE;
      priority if (source_byte > stt_pkg::CHAR_MAX) begin
        seg_b    = one(stt_pkg::KIND_ERROR, stt_pkg::CLS_KEYWORD, source_byte);
        mode_mid = stt_pkg::MODE_HALT;
      end else if (source_byte == CH_LF) begin
        line_mid = line_inc;
      end else if (source_byte == " " || source_byte == 8'h09 || source_byte == 8'h0D ||
                   source_byte == 8'h0B || source_byte == 8'h0C) begin
      end else if (source_byte == "/") begin
        mode_mid = stt_pkg::MODE_SLASH;
      end else if (is_alpha(source_byte)) begin
        mode_mid = stt_pkg::MODE_WORD;
        hold_we  = 1'b1;
        hold_idx = 3'd0;
        len_mid  = 3'd1;
        ovf_mid  = 1'b0;
      end else if (is_digit(source_byte)) begin
        mode_mid = stt_pkg::MODE_NUM;
        dot_mid  = 1'b0;
        seg_b    = one(stt_pkg::KIND_VALUE, stt_pkg::CLS_NUMBER, source_byte);
      end else if (source_byte == "\"") begin
        mode_mid = stt_pkg::MODE_STR;
      end else if (source_byte == "!") begin
        mode_mid = stt_pkg::MODE_BANG;
      end else if (source_byte == "=") begin
        mode_mid = stt_pkg::MODE_EQ;
      end else if (source_byte == "<" || source_byte == ">") begin
        mode_mid = stt_pkg::MODE_ANGLE;
        ang_mid  = (source_byte == ">");
      end else if (source_byte == "{" || source_byte == "}" || source_byte == "[" ||
                   source_byte == "]" || source_byte == ";") begin
        seg_b = pair(source_byte, stt_pkg::CLS_SIGN);
      end else if (source_byte == "+" || source_byte == "-" || source_byte == "*") begin
        seg_b = pair(source_byte, stt_pkg::CLS_OP);
      end else begin
      end
    end

    // Held word as it stands after this byte
    for (int i = 0; i < 5; i++) begin
      hold_eff[i] = (hold_we && hold_idx == 3'(i)) ? source_byte : word_hold[i];
    end

    // Flush a pending token on the last byte
    if (end_of_source) begin
      unique case (mode_mid)
        stt_pkg::MODE_WORD:  seg_c = end_word(hold_eff, len_mid, ovf_mid);
        stt_pkg::MODE_NUM:   seg_c = one(stt_pkg::KIND_END, stt_pkg::CLS_NUMBER, 8'h00);
        stt_pkg::MODE_STR:   seg_c = one(stt_pkg::KIND_END, stt_pkg::CLS_STRING, 8'h00);
        stt_pkg::MODE_SLASH: seg_c = pair("/", stt_pkg::CLS_OP);
        stt_pkg::MODE_EQ:    seg_c = pair("=", stt_pkg::CLS_SIGN);
        stt_pkg::MODE_ANGLE: seg_c = pair(ang_mid ? ">" : "<", stt_pkg::CLS_COMPARE);
        default:             seg_c = '0;
      endcase
      mode_next            = stt_pkg::MODE_IDLE;
      word_length_next     = 3'd0;
      word_overflowed_next = 1'b0;
      dot_seen_next        = 1'b0;
      pending_angle_next   = 1'b0;
      line_count_next      = LINE_COUNT_BITS'(1);
    end else begin
      mode_next            = mode_mid;
      word_length_next     = len_mid;
      word_overflowed_next = ovf_mid;
      dot_seen_next        = dot_mid;
      pending_angle_next   = ang_mid;
      line_count_next      = line_mid;
    end
  end

  // Line carried by every result of this byte: a newline inside a string counts first
  assign line_emit = (mode == stt_pkg::MODE_STR) ? line_mid : line_count;
  assign line_wide = LW'(line_emit);

  // Pack the three segments into one job
  always_comb begin
    logic [3:0] j;
    logic [3:0] k;
    job.cnt  = seg_a.cnt + seg_b.cnt + seg_c.cnt;
    job.line = line_wide[15:0];
    for (int i = 0; i < stt_pkg::MAX_RES; i++) begin
      j = 4'(i) - seg_a.cnt;
      k = j - seg_b.cnt;
      if (4'(i) < seg_a.cnt) begin
        job.ent[i] = seg_a.ent[i];
      end else if (j < seg_b.cnt) begin
        job.ent[i] = seg_b.ent[j[2:0]];
      end else begin
        job.ent[i] = seg_c.ent[k[2:0]];
      end
    end
  end

  assign push = accept && (job.cnt != 4'd0);

  // Scanner state register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= stt_pkg::MODE_IDLE;
      word_length     <= 3'd0;
      word_overflowed <= 1'b0;
      dot_seen        <= 1'b0;
      pending_angle   <= 1'b0;
      line_count      <= LINE_COUNT_BITS'(1);
    end else if (accept) begin
      mode            <= mode_next;
      word_length     <= word_length_next;
      word_overflowed <= word_overflowed_next;
      dot_seen        <= dot_seen_next;
      pending_angle   <= pending_angle_next;
      line_count      <= line_count_next;
    end
  end

  // Hold word characters
  always_ff @(posedge clk) begin
    if (accept && hold_we) begin
      word_hold[hold_idx] <= source_byte;
    end
  end

`ifndef NO_ASSERTIONS
  a_halt_stays: assert property (@(posedge clk) disable iff (rst)
    (mode == stt_pkg::MODE_HALT && !(accept && end_of_source)) |=>
      mode == stt_pkg::MODE_HALT)
    else $error("halted scanner left halt without end of source");
  a_job_fits: assert property (@(posedge clk) disable iff (rst)
    accept |-> job.cnt <= 4'(stt_pkg::MAX_RES))
    else $error("job holds more results than a byte may cause");
`endif

endmodule

### hw/rtl/stt_queue.sv
module stt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  stt_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output stt_pkg::job_t head
);

  stt_pkg::job_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> !full)
    else $error("job pushed into a full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("job popped from an empty queue");
`endif

endmodule

### hw/rtl/stt_back.sv
module stt_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  stt_pkg::job_t q_head,
  output logic          pop,
  output logic          res_valid,
  input  logic          res_ready,
  output logic [1:0]    result_kind,
  output logic [2:0]    token_class,
  output logic [7:0]    value_char,
  output logic [15:0]   line_number,
  output logic          last_of_run
);

  stt_pkg::job_t     cur;
  logic              busy;
  logic [2:0]        idx;
  logic              take;
  logic              last;
  stt_pkg::res_ent_t ent;

  assign ent  = cur.ent[idx];
  assign last = ({1'b0, idx} == cur.cnt - 4'd1);
  assign take = busy && res_ready;
  assign pop  = q_valid && (!busy || (take && last));

  assign res_valid   = busy;
  assign result_kind = ent.kind;
  assign token_class = ent.cls;
  assign value_char  = ent.ch;
  assign line_number = cur.line;
  assign last_of_run = last;

  // Load the next job
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
  end

  // Step through the results of the current job
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= 3'd0;
    end else if (take && last) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (take) begin
      idx <= idx + 3'd1;
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    busy |-> ({1'b0, idx} < cur.cnt))
    else $error("result index beyond job length");
  a_job_held: assert property (@(posedge clk) disable iff (rst)
    (busy && !(take && last)) |=> (busy && $stable(cur)))
    else $error("job changed before its last result was taken");
`endif

endmodule

### hw/rtl/source_text_tokenizer.sv
// An accepted byte's result items are written into the queue, then loaded into the result sequencer,
// which presents the first item.
// Throughput: one byte per cycle while the queue is not full; a byte causing n result items presents them in turn.
// A two-job queue between the scanner and the result sequencer absorbs result bursts.
// Reset (synchronous, active high): scanner idle, line count one, queue and output empty.
module source_text_tokenizer #(
  parameter int LINE_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_ready,
  input  logic [7:0]  source_byte,
  input  logic        end_of_source,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [1:0]  result_kind,
  output logic [2:0]  token_class,
  output logic [7:0]  value_char,
  output logic [15:0] line_number,
  output logic        last_of_run
);

  stt_pkg::job_t push_job;
  stt_pkg::job_t head_job;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_valid;

  stt_front #(
    .LINE_COUNT_BITS(LINE_COUNT_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .source_byte  (source_byte),
    .end_of_source(end_of_source),
    .src_valid    (src_valid),
    .src_ready    (src_ready),
    .q_ready      (!q_full),
    .push         (push),
    .job          (push_job)
  );

  stt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .head_valid(q_valid),
    .head      (head_job)
  );

  stt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (head_job),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .result_kind(result_kind),
    .token_class(token_class),
    .value_char (value_char),
    .line_number(line_number),
    .last_of_run(last_of_run)
  );

endmodule
